// File: rtl/chunky_to_planar_masked_writer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunky-to-planar masked writer
// Concurrent checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CHUNKY_TO_PLANAR_MASKED_WRITER_ASSERT_SVH
`define CHUNKY_TO_PLANAR_MASKED_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define C2P_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("c2p check failed");
// cond must never be true out of reset
`define C2P_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("c2p forbidden condition seen");
`else
`define C2P_ASSERT(label, prop)
`define C2P_ASSERT_NEVER(label, cond)
`endif

`endif

// File: rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants, register indexes and types of the chunky-to-planar writer.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

   localparam int MAX_PLANES_DEF = 4;
   localparam int ADDR_BITS_DEF  = 16;

   // bursts buffered between the pixel front end and the write back end
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_NUM_PLANES    = 2'd0,
      REG_START_BIT     = 2'd1,
      REG_START_ADDRESS = 2'd2,
      REG_LINE_BYTES    = 2'd3
   } csr_index_type;

   localparam logic [2:0]  NUM_PLANES_RST    = 3'd4;
   localparam logic [2:0]  START_BIT_RST     = 3'd0;
   localparam logic [15:0] START_ADDRESS_RST = 16'd0;
   localparam logic [12:0] LINE_BYTES_RST    = 13'd81;

   localparam logic [7:0] FIRST_BIT_MASK = 8'h80;
   localparam logic [2:0] LAST_BIT_POS   = 3'd7;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

// File: rtl/chunky_to_planar_masked_writer.sv
// ----------------------------------------------------------------------------
// chunky_to_planar_masked_writer
// Splits 8-bit indexed pixels into bitplanes and emits masked byte writes.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle. A pixel that fills bit 0 of a byte or ends a
// row closes a burst of one masked write per active plane (plane 0 first, last
// flagged); bursts wait in a two-deep queue and leave through a registered
// output at one write per cycle while rsp_stall is low, passing through the
// queue and then the output register. Pixel intake stalls only while the queue
// is full, so the sustained rate is one pixel per cycle as long as each burst
// of N plane writes is spread over at least N pixels; with row ends closer
// together than that the write port sets the pace. Writing start_bit or
// start_address restarts the frame and drops a partly filled byte.
`default_nettype none

module chunky_to_planar_masked_writer #(
   parameter  int MAX_PLANES = c2p_pkg::MAX_PLANES_DEF,
   parameter  int ADDR_BITS  = c2p_pkg::ADDR_BITS_DEF,
   localparam int PLANE_BITS = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [7:0]                         req_pixel_index,
   input  wire logic                               req_row_end,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [PLANE_BITS-1:0]              rsp_plane,
   output      logic [ADDR_BITS-1:0]               rsp_byte_address,
   output      logic [7:0]                         rsp_write_mask,
   output      logic [7:0]                         rsp_plane_bits,
   output      logic                               rsp_last,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [c2p_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [c2p_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output      logic [c2p_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output      logic                               csr_pready
);
   import c2p_pkg::*;

   localparam int PCNT_BITS  = $clog2(MAX_PLANES + 1);
   localparam int ENTRY_BITS = ADDR_BITS + 8 + MAX_PLANES * 8 + PCNT_BITS;

   logic [2:0]   num_planes_ff, num_planes_in;
   logic [2:0]   start_bit_ff, start_bit_in;
   logic [15:0]  start_address_ff, start_address_in;
   logic [12:0]  line_bytes_ff, line_bytes_in;

   logic                     csr_write;
   csr_index_type            csr_index;
   logic                     restart;
   logic [PCNT_BITS-1:0]     active_planes;

   queue_status_type         qstat;
   logic                     push;
   logic                     pop;
   logic [ADDR_BITS-1:0]     push_address;
   logic [7:0]               push_mask;
   logic [MAX_PLANES*8-1:0]  push_data;
   logic [PCNT_BITS-1:0]     push_count;
   logic [ENTRY_BITS-1:0]    push_entry;
   logic [ENTRY_BITS-1:0]    head_entry;
   logic [ADDR_BITS-1:0]     head_address;
   logic [7:0]               head_mask;
   logic [MAX_PLANES*8-1:0]  head_data;
   logic [PCNT_BITS-1:0]     head_count;

   // configuration registers
   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      csr_index  = csr_index_type'(csr_paddr[3:2]);

      num_planes_in    = num_planes_ff;
      start_bit_in     = start_bit_ff;
      start_address_in = start_address_ff;
      line_bytes_in    = line_bytes_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_NUM_PLANES:    num_planes_in    = csr_pwdata[2:0];
            REG_START_BIT:     start_bit_in     = csr_pwdata[2:0];
            REG_START_ADDRESS: start_address_in = csr_pwdata[15:0];
            REG_LINE_BYTES:    line_bytes_in    = csr_pwdata[12:0];
            default:           num_planes_in    = num_planes_ff;
         endcase
      end
      restart = csr_write &&
                (csr_index == REG_START_BIT || csr_index == REG_START_ADDRESS);

      unique case (csr_index)
         REG_NUM_PLANES:    csr_prdata = CSR_DATA_BITS'(num_planes_ff);
         REG_START_BIT:     csr_prdata = CSR_DATA_BITS'(start_bit_ff);
         REG_START_ADDRESS: csr_prdata = CSR_DATA_BITS'(start_address_ff);
         REG_LINE_BYTES:    csr_prdata = CSR_DATA_BITS'(line_bytes_ff);
         default:           csr_prdata = '0;
      endcase

      // zero planes acts as one, too many clamps to the maximum
      if (num_planes_ff == 3'd0) begin
         active_planes = PCNT_BITS'(1);
      end else if ({1'b0, num_planes_ff} > 4'(MAX_PLANES)) begin
         active_planes = PCNT_BITS'(MAX_PLANES);
      end else begin
         active_planes = PCNT_BITS'(num_planes_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_planes_ff    <= NUM_PLANES_RST;
         start_bit_ff     <= START_BIT_RST;
         start_address_ff <= START_ADDRESS_RST;
         line_bytes_ff    <= LINE_BYTES_RST;
      end else begin
         num_planes_ff    <= num_planes_in;
         start_bit_ff     <= start_bit_in;
         start_address_ff <= start_address_in;
         line_bytes_ff    <= line_bytes_in;
      end
   end

   c2p_front #(
      .MAX_PLANES (MAX_PLANES),
      .ADDR_BITS  (ADDR_BITS),
      .PCNT_BITS  (PCNT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_stall       (req_stall),
      .in_pixel_index (req_pixel_index),
      .in_row_end     (req_row_end),
      .restart        (restart),
      .start_bit      (start_bit_in),
      .start_address  (ADDR_BITS'(start_address_in)),
      .line_bytes     (ADDR_BITS'(line_bytes_ff)),
      .active_planes  (active_planes),
      .qstat          (qstat),
      .push           (push),
      .push_address   (push_address),
      .push_mask      (push_mask),
      .push_data      (push_data),
      .push_count     (push_count)
   );

   assign push_entry = {push_address, push_mask, push_data, push_count};

   c2p_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .head_data (head_entry),
      .status    (qstat)
   );

   assign {head_address, head_mask, head_data, head_count} = head_entry;

   c2p_back #(
      .MAX_PLANES (MAX_PLANES),
      .ADDR_BITS  (ADDR_BITS),
      .PCNT_BITS  (PCNT_BITS),
      .PLANE_BITS (PLANE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .qstat            (qstat),
      .head_address     (head_address),
      .head_mask        (head_mask),
      .head_data        (head_data),
      .head_count       (head_count),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_plane        (rsp_plane),
      .rsp_byte_address (rsp_byte_address),
      .rsp_write_mask   (rsp_write_mask),
      .rsp_plane_bits   (rsp_plane_bits),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/c2p_queue.sv
// ----------------------------------------------------------------------------
// c2p_queue
// Small register queue of finished bursts between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = c2p_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire logic [WIDTH-1:0]         push_data,
   input  wire logic                     pop,
   output      logic [WIDTH-1:0]         head_data,
   output      c2p_pkg::queue_status_type status
);
   import c2p_pkg::*;

`include "chunky_to_planar_masked_writer_assert.svh"

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == CNT_BITS'(DEPTH));
      head_data    = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `C2P_ASSERT_NEVER(a_queue_overflow, push && status.full)
   `C2P_ASSERT_NEVER(a_queue_underflow, pop && status.empty)

endmodule

`default_nettype wire

// File: rtl/c2p_front.sv
// ----------------------------------------------------------------------------
// c2p_front
// Pixel front end: splits pixels into plane bits and closes bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_front #(
   parameter int MAX_PLANES = c2p_pkg::MAX_PLANES_DEF,
   parameter int ADDR_BITS  = c2p_pkg::ADDR_BITS_DEF,
   parameter int PCNT_BITS  = $clog2(MAX_PLANES + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_stall,
   input  wire logic [7:0]                  in_pixel_index,
   input  wire logic                        in_row_end,
   input  wire logic                        restart,
   input  wire logic [2:0]                  start_bit,
   input  wire logic [ADDR_BITS-1:0]        start_address,
   input  wire logic [ADDR_BITS-1:0]        line_bytes,
   input  wire logic [PCNT_BITS-1:0]        active_planes,
   input  wire c2p_pkg::queue_status_type   qstat,
   output      logic                        push,
   output      logic [ADDR_BITS-1:0]        push_address,
   output      logic [7:0]                  push_mask,
   output      logic [MAX_PLANES*8-1:0]     push_data,
   output      logic [PCNT_BITS-1:0]        push_count
);
   import c2p_pkg::*;

`include "chunky_to_planar_masked_writer_assert.svh"

   logic [2:0]                      bit_pos_ff, bit_pos_in;
   logic [ADDR_BITS-1:0]            cur_addr_ff, cur_addr_in;
   logic [ADDR_BITS-1:0]            row_addr_ff, row_addr_in;
   logic [7:0]                      covered_ff, covered_in;
   logic [MAX_PLANES-1:0][7:0]      acc_ff, acc_in;

   logic [MAX_PLANES-1:0][7:0]      acc_next;
   logic [7:0]                      bit_mask;
   logic [7:0]                      covered_next;
   logic [ADDR_BITS-1:0]            row_next;
   logic                            accept;
   logic                            flush;

   always_comb begin
      in_stall     = qstat.full;
      accept       = in_valid && !qstat.full;
      bit_mask     = FIRST_BIT_MASK >> bit_pos_ff;
      covered_next = covered_ff | bit_mask;
      flush        = (bit_pos_ff == LAST_BIT_POS) || in_row_end;
      row_next     = row_addr_ff + line_bytes;

      // inactive planes keep their bits
      for (int k = 0; k < MAX_PLANES; k++) begin
         if (PCNT_BITS'(k) < active_planes) begin
            acc_next[k] = in_pixel_index[k] ? (acc_ff[k] | bit_mask)
                                            : (acc_ff[k] & ~bit_mask);
         end else begin
            acc_next[k] = acc_ff[k];
         end
         push_data[k*8 +: 8] = acc_next[k] & covered_next;
      end

      push         = accept && flush;
      push_address = cur_addr_ff;
      push_mask    = covered_next;
      push_count   = active_planes;

      bit_pos_in  = bit_pos_ff;
      cur_addr_in = cur_addr_ff;
      row_addr_in = row_addr_ff;
      covered_in  = covered_ff;
      acc_in      = acc_ff;
      priority if (restart) begin
         // new origin: drop any partly filled byte
         bit_pos_in  = start_bit;
         cur_addr_in = start_address;
         row_addr_in = start_address;
         covered_in  = '0;
         acc_in      = '0;
      end else if (accept) begin
         if (flush) begin
            covered_in = '0;
            acc_in     = '0;
            if (in_row_end) begin
               row_addr_in = row_next;
               cur_addr_in = row_next;
               bit_pos_in  = start_bit;
            end else begin
               cur_addr_in = cur_addr_ff + ADDR_BITS'(1);
               bit_pos_in  = '0;
            end
         end else begin
            covered_in = covered_next;
            acc_in     = acc_next;
            bit_pos_in = bit_pos_ff + 3'd1;
         end
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_pos_ff  <= START_BIT_RST;
         cur_addr_ff <= ADDR_BITS'(START_ADDRESS_RST);
         row_addr_ff <= ADDR_BITS'(START_ADDRESS_RST);
         covered_ff  <= '0;
         acc_ff      <= '0;
      end else begin
         bit_pos_ff  <= bit_pos_in;
         cur_addr_ff <= cur_addr_in;
         row_addr_ff <= row_addr_in;
         covered_ff  <= covered_in;
         acc_ff      <= acc_in;
      end
   end

   `C2P_ASSERT(a_front_advance, accept && !flush && !restart |=> bit_pos_ff == $past(bit_pos_ff) + 3'd1)
   `C2P_ASSERT(a_front_flush_clears, accept && flush && !restart |=> covered_ff == 8'h00)

endmodule

`default_nettype wire

// File: rtl/c2p_back.sv
// ----------------------------------------------------------------------------
// c2p_back
// Write back end: walks each queued burst one plane write per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_back #(
   parameter int MAX_PLANES = c2p_pkg::MAX_PLANES_DEF,
   parameter int ADDR_BITS  = c2p_pkg::ADDR_BITS_DEF,
   parameter int PCNT_BITS  = $clog2(MAX_PLANES + 1),
   parameter int PLANE_BITS = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire c2p_pkg::queue_status_type   qstat,
   input  wire logic [ADDR_BITS-1:0]        head_address,
   input  wire logic [7:0]                  head_mask,
   input  wire logic [MAX_PLANES*8-1:0]     head_data,
   input  wire logic [PCNT_BITS-1:0]        head_count,
   output      logic                        pop,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic [PLANE_BITS-1:0]       rsp_plane,
   output      logic [ADDR_BITS-1:0]        rsp_byte_address,
   output      logic [7:0]                  rsp_write_mask,
   output      logic [7:0]                  rsp_plane_bits,
   output      logic                        rsp_last
);
   import c2p_pkg::*;

`include "chunky_to_planar_masked_writer_assert.svh"

   logic [PLANE_BITS-1:0]  plane_ff, plane_in;
   logic                   valid_ff, valid_in;
   logic [PLANE_BITS-1:0]  out_plane_ff;
   logic [ADDR_BITS-1:0]   out_addr_ff;
   logic [7:0]             out_mask_ff;
   logic [7:0]             out_bits_ff;
   logic                   out_last_ff;

   logic                   load;
   logic                   is_last;

   always_comb begin
      load     = !qstat.empty && (!valid_ff || !rsp_stall);
      is_last  = (PCNT_BITS'(plane_ff) + PCNT_BITS'(1)) == head_count;
      pop      = load && is_last;
      plane_in = plane_ff;
      if (load) begin
         plane_in = is_last ? '0 : plane_ff + PLANE_BITS'(1);
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         plane_ff <= plane_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_plane_ff <= plane_ff;
         out_addr_ff  <= head_address;
         out_mask_ff  <= head_mask;
         out_bits_ff  <= head_data[{plane_ff, 3'b000} +: 8];
         out_last_ff  <= is_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_plane        = out_plane_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_write_mask   = out_mask_ff;
   assign rsp_plane_bits   = out_bits_ff;
   assign rsp_last         = out_last_ff;

   `C2P_ASSERT(a_back_plane_in_burst, !qstat.empty |-> PCNT_BITS'(plane_ff) < head_count)
   `C2P_ASSERT(a_back_idle_at_start, qstat.empty |-> plane_ff == '0)

endmodule

`default_nettype wire
